/* rtl/vdds_pkg.sv */
// vdds_pkg: shared types, codes and defaults for the voted debounce drive selector
// used by vdds_lane, vdds_merge and voted_debounce_drive_selector
// no dependencies
package vdds_pkg;

  // default sizing
  localparam int LANES_DEF      = 6;
  localparam int TIMER_BITS_DEF = 16;
  localparam int MAX_WINDOW_DEF = 15;

  // fixed pin lanes
  localparam int PIN_LANES     = 6;
  localparam int LANE_LEFT     = 0;
  localparam int LANE_RIGHT    = 1;
  localparam int LANE_GEAR     = 2;
  localparam int LANE_THROTTLE = 3;
  localparam int LANE_MODE_A   = 4;
  localparam int LANE_MODE_B   = 5;
  localparam int IN_TICK_BIT   = 6;

  // configuration register indexes
  localparam logic [2:0] REG_STEER_DEB    = 3'd0;
  localparam logic [2:0] REG_GEAR_DEB     = 3'd1;
  localparam logic [2:0] REG_THROTTLE_DEB = 3'd2;
  localparam logic [2:0] REG_MODE_DEB     = 3'd3;
  localparam logic [2:0] REG_VOTE_SAMPLES = 3'd4;
  localparam logic [2:0] REG_VOTE_THRESH  = 3'd5;
  localparam logic [2:0] REG_POLARITY     = 3'd6;

  // configuration reset values
  localparam logic [15:0] STEER_DEB_RST    = 16'd20;
  localparam logic [15:0] GEAR_DEB_RST     = 16'd50;
  localparam logic [15:0] THROTTLE_DEB_RST = 16'd50;
  localparam logic [15:0] MODE_DEB_RST     = 16'd50;
  localparam logic [3:0]  VOTE_SAMPLES_RST = 4'd5;
  localparam logic [3:0]  VOTE_THRESH_RST  = 4'd3;
  localparam logic [2:0]  POLARITY_RST     = 3'd7;

  // polarity bits
  localparam int POL_THROTTLE = 0;
  localparam int POL_DIR      = 1;
  localparam int POL_LED      = 2;

  // steering codes
  localparam logic [1:0] STEER_CENTER = 2'd0;
  localparam logic [1:0] STEER_LEFT   = 2'd1;
  localparam logic [1:0] STEER_RIGHT  = 2'd2;
  localparam logic [1:0] STEER_ERR    = 2'd3;

  // mode codes
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_REMOTE = 2'd2;
  localparam logic [1:0] MODE_ERR    = 2'd3;

  // actuator commands
  localparam logic [1:0] CMD_BRAKE   = 2'd0;
  localparam logic [1:0] CMD_EXTEND  = 2'd1;
  localparam logic [1:0] CMD_RETRACT = 2'd2;

  // drive gear, two bit signed
  localparam logic signed [1:0] DRIVE_NEUTRAL = 2'sb00;
  localparam logic signed [1:0] DRIVE_FWD     = 2'sb01;
  localparam logic signed [1:0] DRIVE_REV     = 2'sb11;

  // per item control to every lane
  typedef struct packed {
    logic accept;
    logic tick;
    logic close;
  } lane_ctrl_t;

  // one result transaction
  typedef struct packed {
    logic              window_done;
    logic              throttle_pin;
    logic              dir_pin;
    logic              led_auto;
    logic              led_manual;
    logic              led_remote;
    logic              actuator_strobe;
    logic [1:0]        actuator_cmd;
    logic [1:0]        steering_code;
    logic signed [1:0] drive_gear;
    logic [1:0]        mode_code;
  } result_t;

endpackage

/* rtl/vdds_lane.sv */
// vdds_lane: one switch lane, window vote count, voted level, ms timer, stable level
// depends on vdds_pkg
module vdds_lane
  import vdds_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lane_ctrl_t  ctrl,
  input  logic        sample,
  input  logic [3:0]  thresh,
  input  logic [15:0] debounce_ms,
  output logic        stable_nxt
);

  localparam int HVW = $clog2(MAX_WINDOW + 1);
  localparam int CW  = (HVW > 4) ? HVW : 4;
  localparam int DW  = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [HVW-1:0]        hv_r, hv_nxt, hv_sum;
  logic [TIMER_BITS-1:0] since_r, since_nxt, since_tick;
  logic                  voted_r, voted_nxt;
  logic                  stable_r;
  logic                  vote;

  always_comb begin
    hv_sum     = hv_r + HVW'(sample);
    vote       = CW'(hv_sum) >= CW'(thresh);
    since_tick = (ctrl.tick && (since_r != '1)) ? since_r + 1'b1 : since_r;
    hv_nxt     = hv_sum;
    since_nxt  = since_tick;
    voted_nxt  = voted_r;
    stable_nxt = stable_r;
    if (ctrl.close) begin
      hv_nxt    = '0;
      voted_nxt = vote;
      if (vote != voted_r) begin
        since_nxt = '0;
      end
      if ((stable_r != vote) && (DW'(since_nxt) >= DW'(debounce_ms))) begin
        stable_nxt = vote;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r     <= '0;
      since_r  <= '0;
      voted_r  <= 1'b1;
      stable_r <= 1'b1;
    end else if (ctrl.accept) begin
      hv_r     <= hv_nxt;
      since_r  <= since_nxt;
      voted_r  <= voted_nxt;
      stable_r <= stable_nxt;
    end
  end

endmodule

/* rtl/vdds_merge.sv */
// vdds_merge: decodes lane stable levels into steering, mode, drive and actuator command
// depends on vdds_pkg
module vdds_merge
  import vdds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  lane_ctrl_t           ctrl,
  input  logic [PIN_LANES-1:0] stable,
  input  logic [2:0]           polarity,
  output result_t              res
);

  logic [1:0]        prev_steer_r, prev_mode_r;
  logic [1:0]        stat_steer_r, stat_mode_r;
  logic signed [1:0] stat_drive_r;
  logic [1:0]        steer_new, mode_new;
  logic signed [1:0] drive_new;
  logic [1:0]        stat_steer_nxt, stat_mode_nxt;
  logic signed [1:0] stat_drive_nxt;
  logic              left_act, right_act, mode_a, mode_b;
  logic              strobe;
  logic [1:0]        cmd;

  always_comb begin
    left_act  = !stable[LANE_LEFT];
    right_act = !stable[LANE_RIGHT];
    mode_a    = stable[LANE_MODE_A];
    mode_b    = stable[LANE_MODE_B];
    unique case ({left_act, right_act})
      2'b10:   steer_new = STEER_LEFT;
      2'b01:   steer_new = STEER_RIGHT;
      2'b00:   steer_new = STEER_CENTER;
      default: steer_new = STEER_ERR;
    endcase
    unique case ({mode_a, mode_b})
      2'b10:   mode_new = MODE_AUTO;
      2'b11:   mode_new = MODE_MANUAL;
      2'b01:   mode_new = MODE_REMOTE;
      default: mode_new = MODE_ERR;
    endcase
    drive_new = DRIVE_NEUTRAL;
    if ((mode_new == MODE_MANUAL) && stable[LANE_THROTTLE]) begin
      drive_new = stable[LANE_GEAR] ? DRIVE_REV : DRIVE_FWD;
    end

    strobe = 1'b0;
    cmd    = CMD_BRAKE;
    if (ctrl.close) begin
      if (mode_new == MODE_MANUAL) begin
        if ((mode_new != prev_mode_r) || (steer_new != prev_steer_r)) begin
          strobe = 1'b1;
          unique case (steer_new)
            STEER_LEFT:  cmd = CMD_EXTEND;
            STEER_RIGHT: cmd = CMD_RETRACT;
            default:     cmd = CMD_BRAKE;
          endcase
        end
      end else if (mode_new != prev_mode_r) begin
        strobe = 1'b1;
      end
    end

    stat_steer_nxt = ctrl.close ? steer_new : stat_steer_r;
    stat_mode_nxt  = ctrl.close ? mode_new  : stat_mode_r;
    stat_drive_nxt = ctrl.close ? drive_new : stat_drive_r;

    // pin is high when active matches the polarity bit
    res.window_done     = ctrl.close;
    res.throttle_pin    = (stat_drive_nxt != DRIVE_NEUTRAL) == polarity[POL_THROTTLE];
    res.dir_pin         = (stat_drive_nxt == DRIVE_REV) == polarity[POL_DIR];
    res.led_auto        = (stat_mode_nxt == MODE_AUTO) == polarity[POL_LED];
    res.led_manual      = (stat_mode_nxt == MODE_MANUAL) == polarity[POL_LED];
    res.led_remote      = (stat_mode_nxt == MODE_REMOTE) == polarity[POL_LED];
    res.actuator_strobe = strobe;
    res.actuator_cmd    = cmd;
    res.steering_code   = stat_steer_nxt;
    res.drive_gear      = stat_drive_nxt;
    res.mode_code       = stat_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_steer_r <= STEER_ERR;
      prev_mode_r  <= MODE_ERR;
      stat_steer_r <= STEER_CENTER;
      stat_mode_r  <= MODE_MANUAL;
      stat_drive_r <= DRIVE_NEUTRAL;
    end else if (ctrl.accept && ctrl.close) begin
      prev_steer_r <= steer_new;
      prev_mode_r  <= mode_new;
      stat_steer_r <= stat_steer_nxt;
      stat_mode_r  <= stat_mode_nxt;
      stat_drive_r <= stat_drive_nxt;
    end
  end

endmodule

/* rtl/voted_debounce_drive_selector.sv */
// voted_debounce_drive_selector: top level, apb register file, window counter,
// parallel debounce lanes, decode merge and output register
// depends on vdds_pkg, vdds_lane, vdds_merge
// latency: a result transaction is offered the cycle after its input transaction is accepted
// throughput: one transaction per cycle while out_tready is high; lanes and decode complete in a single stage
// the output register frees on the same edge it is taken, so back-to-back flow stalls only while out_tready is low
// reset: synchronous active-low rst_n clears the window, all lane counters, sets voted and
// stable levels idle high, status to center/neutral/manual and registers to defaults
module voted_debounce_drive_selector
  import vdds_pkg::*;
#(
  parameter int LANES      = LANES_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] steer_left_raw [1] steer_right_raw [2] gear_raw [3] throttle_raw
  // [4] mode_a_raw [5] mode_b_raw [6] ms_tick [7] zero
  input  logic [7:0]  in_tdata,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] window_done [1] throttle_pin [2] dir_pin [3] led_auto [4] led_manual
  // [5] led_remote [6] actuator_strobe [8:7] actuator_cmd [10:9] steering_code
  // [12:11] drive_gear [14:13] mode_code [15] zero
  output logic [15:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int HVW = $clog2(MAX_WINDOW + 1);
  localparam int WW  = ((HVW > 4) ? HVW : 4) + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] steer_deb_r, gear_deb_r, throttle_deb_r, mode_deb_r;
  logic [3:0]  vote_samples_r, vote_thresh_r;
  logic [2:0]  polarity_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_deb_r    <= STEER_DEB_RST;
      gear_deb_r     <= GEAR_DEB_RST;
      throttle_deb_r <= THROTTLE_DEB_RST;
      mode_deb_r     <= MODE_DEB_RST;
      vote_samples_r <= VOTE_SAMPLES_RST;
      vote_thresh_r  <= VOTE_THRESH_RST;
      polarity_r     <= POLARITY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEER_DEB:    steer_deb_r    <= cfg_pwdata[15:0];
        REG_GEAR_DEB:     gear_deb_r     <= cfg_pwdata[15:0];
        REG_THROTTLE_DEB: throttle_deb_r <= cfg_pwdata[15:0];
        REG_MODE_DEB:     mode_deb_r     <= cfg_pwdata[15:0];
        REG_VOTE_SAMPLES: vote_samples_r <= cfg_pwdata[3:0];
        REG_VOTE_THRESH:  vote_thresh_r  <= cfg_pwdata[3:0];
        REG_POLARITY:     polarity_r     <= cfg_pwdata[2:0];
        default: ;  // unmapped address, write ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STEER_DEB:    cfg_prdata = {16'd0, steer_deb_r};
      REG_GEAR_DEB:     cfg_prdata = {16'd0, gear_deb_r};
      REG_THROTTLE_DEB: cfg_prdata = {16'd0, throttle_deb_r};
      REG_MODE_DEB:     cfg_prdata = {16'd0, mode_deb_r};
      REG_VOTE_SAMPLES: cfg_prdata = {28'd0, vote_samples_r};
      REG_VOTE_THRESH:  cfg_prdata = {28'd0, vote_thresh_r};
      REG_POLARITY:     cfg_prdata = {29'd0, polarity_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake and output register
  // ---------------------------------------------------------------------------
  logic    in_acc;
  logic    out_valid_r;
  result_t out_data_r;
  result_t res;

  // take a new transaction whenever the output slot is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // vote window counter, shared by all lanes
  // ---------------------------------------------------------------------------
  logic [HVW-1:0] wc_r;
  logic [WW-1:0]  wc_inc, win_size;
  logic           close;

  always_comb begin
    // zero samples acts as one, oversize clamps to the window limit
    if (vote_samples_r == 4'd0) begin
      win_size = WW'(1);
    end else if (WW'(vote_samples_r) > WW'(MAX_WINDOW)) begin
      win_size = WW'(MAX_WINDOW);
    end else begin
      win_size = WW'(vote_samples_r);
    end
    wc_inc = WW'(wc_r) + WW'(1);
    close  = wc_inc >= win_size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0;
    end else if (in_acc) begin
      wc_r <= close ? '0 : wc_inc[HVW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // parallel lanes
  // ---------------------------------------------------------------------------
  lane_ctrl_t           lctrl;
  logic [LANES-1:0]     lane_stable;
  logic [PIN_LANES-1:0] stable6;

  assign lctrl.accept = in_acc;
  assign lctrl.tick   = in_tdata[IN_TICK_BIT];
  assign lctrl.close  = close;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic        lane_sample;
    logic [15:0] lane_deb;

    // lanes past the pin set sample idle high
    if (i < PIN_LANES) begin : g_pin
      assign lane_sample = in_tdata[i];
    end else begin : g_idle
      assign lane_sample = 1'b1;
    end

    if ((i == LANE_LEFT) || (i == LANE_RIGHT)) begin : g_steer
      assign lane_deb = steer_deb_r;
    end else if (i == LANE_GEAR) begin : g_gear
      assign lane_deb = gear_deb_r;
    end else if (i == LANE_THROTTLE) begin : g_thr
      assign lane_deb = throttle_deb_r;
    end else begin : g_mode
      assign lane_deb = mode_deb_r;
    end

    vdds_lane #(
      .TIMER_BITS (TIMER_BITS),
      .MAX_WINDOW (MAX_WINDOW)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (lctrl),
      .sample      (lane_sample),
      .thresh      (vote_thresh_r),
      .debounce_ms (lane_deb),
      .stable_nxt  (lane_stable[i])
    );
  end

  // decode sees idle high for pins that have no lane
  for (genvar j = 0; j < PIN_LANES; j++) begin : g_stab
    if (j < LANES) begin : g_have
      assign stable6[j] = lane_stable[j];
    end else begin : g_none
      assign stable6[j] = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // merge: decode, actuator command, pin polarity
  // ---------------------------------------------------------------------------
  vdds_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (lctrl),
    .stable   (stable6),
    .polarity (polarity_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_data_r.mode_code,
                       out_data_r.drive_gear,
                       out_data_r.steering_code,
                       out_data_r.actuator_cmd,
                       out_data_r.actuator_strobe,
                       out_data_r.led_remote,
                       out_data_r.led_manual,
                       out_data_r.led_auto,
                       out_data_r.dir_pin,
                       out_data_r.throttle_pin,
                       out_data_r.window_done};

`ifndef SYNTHESIS
  // a strobe only comes with a closed window
  a_strobe_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_data_r.actuator_strobe || out_data_r.window_done))
    else $error("actuator strobe without window close");

  // a command other than brake only comes with a strobe
  a_cmd_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_data_r.actuator_cmd != CMD_BRAKE)) |-> out_data_r.actuator_strobe)
    else $error("actuator command without strobe");

  // closing a window restarts the counter
  a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && close) |=> (wc_r == '0))
    else $error("window counter not cleared on close");

  // the counter never holds a full window
  a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(wc_r) < WW'(MAX_WINDOW))
    else $error("window counter out of range");

  // an accepted transaction always shows up at the output next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted transaction produced no result");
`endif

endmodule
